@@ src/keyframe_joint_motion_player_macros.svh @@
// ------------------------------------------------------------------------
// Keyframe joint motion player assertion macros
// Shorthand for clocked, reset-qualified checks used in the player RTL.
// ------------------------------------------------------------------------
`ifndef KEYFRAME_JOINT_MOTION_PLAYER_MACROS_SVH
`define KEYFRAME_JOINT_MOTION_PLAYER_MACROS_SVH

// same-cycle implication
`define KJMP_ASSERT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KJMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/kjmp_pkg.sv @@
// ------------------------------------------------------------------------
// Keyframe joint motion player package
// Request kinds, register indexes, result and divider interface types.
// ------------------------------------------------------------------------
package kjmp_pkg;

	typedef enum logic [1:0] {
		KIND_FRAME   = 2'd0,
		KIND_TARGET  = 2'd1,
		KIND_SAMPLE  = 2'd2,
		KIND_RESTART = 2'd3
	} kind_t;

	localparam logic REG_FRAME_COUNT = 1'b0;
	localparam logic REG_DEADBAND    = 1'b1;

	localparam int JOINT_W    = 5;
	localparam int SPEED_W    = 16;
	localparam int REPEAT_W   = 8;
	localparam int DIVIDEND_W = 16;
	localparam int DIVISOR_W  = 12;
	localparam int OUT_DATA_W = 32;

	typedef struct packed {
		logic [JOINT_W-1:0]         joint;
		logic signed [SPEED_W-1:0]  speed;
		logic                       holding;
		logic                       finished;
		logic [REPEAT_W-1:0]        repeat_total;
	} res_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} div_sts_t;

endpackage

@@ src/kjmp_div.sv @@
// ------------------------------------------------------------------------
// Bit-serial divider
// Restoring division, one quotient bit per cycle shifted through the
// dividend register.
// ------------------------------------------------------------------------
module kjmp_div (
	input  logic                clk,
	input  logic                arst_n,
	input  kjmp_pkg::div_req_t  req,
	output kjmp_pkg::div_sts_t  sts
);

	localparam int CW = $clog2(kjmp_pkg::DIVIDEND_W);

	logic [kjmp_pkg::DIVIDEND_W-1:0] dq_q;
	logic [kjmp_pkg::DIVISOR_W-1:0]  rem_q;
	logic [kjmp_pkg::DIVISOR_W-1:0]  divisor_q;
	logic [CW-1:0]                   cnt_q;
	logic                            busy_q;
	logic                            done_q;

	logic [kjmp_pkg::DIVISOR_W:0]   trial;
	logic [kjmp_pkg::DIVISOR_W:0]   diff;
	logic                           ge;
	logic [kjmp_pkg::DIVISOR_W-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, dq_q[kjmp_pkg::DIVIDEND_W-1]};
		diff     = trial - {1'b0, divisor_q};
		ge       = (trial >= {1'b0, divisor_q});
		rem_next = ge ? diff[kjmp_pkg::DIVISOR_W-1:0] : trial[kjmp_pkg::DIVISOR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(kjmp_pkg::DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q      <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[kjmp_pkg::DIVIDEND_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign sts.busy     = busy_q;
	assign sts.done     = done_q;
	assign sts.quotient = dq_q;

endmodule

@@ src/kjmp_obuf.sv @@
// ------------------------------------------------------------------------
// Result output register
// One-entry buffer that holds a result until the stream sink takes it.
// ------------------------------------------------------------------------
module kjmp_obuf (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  kjmp_pkg::res_t                      res,
	output logic                                ready,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// joint_out, speed_command, holding, sequence_finished, repeat_total, pad
	output logic [kjmp_pkg::OUT_DATA_W-1:0]     m_tdata
);

	logic           valid_q;
	kjmp_pkg::res_t data_q;

	assign ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, data_q.repeat_total, data_q.finished, data_q.holding,
		data_q.speed, data_q.joint};

endmodule

@@ src/keyframe_joint_motion_player.sv @@
// ------------------------------------------------------------------------
// Keyframe joint motion player
// Keyframe tables, frame search sequencer and speed command generation.
// ------------------------------------------------------------------------
// Frame time and target loads and restarts complete in the idle state. A
// sample of a finished sequence goes straight to the emit state to hand
// its hold result to the output register. A live sample reads the last
// frame's end, scans frames 1 to the last frame in use one per cycle
// through the single frame table read port, reads the target, then runs
// the bit-serial divider (16 quotient bits, one per cycle), and hands any
// result to the output register once it is ready. Samples without an
// active frame, with no time left or inside the deadband skip the divider. No clearing pass.

`include "keyframe_joint_motion_player_macros.svh"

module keyframe_joint_motion_player #(
	parameter int MAX_FRAMES = 16,
	parameter int MAX_JOINTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// frame_index, joint_index, angle, start_tick, end_tick, zero pad
	input  logic [47:0] s_tdata,
	// kind
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// joint_out, speed_command, holding, sequence_finished, repeat_total, pad
	output logic [31:0] m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [7:0]  cfg_wdata
);

	localparam int FW = $clog2(MAX_FRAMES);
	localparam int AW = $clog2(MAX_FRAMES * MAX_JOINTS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LAST,
		ST_SCAN,
		ST_TCALC,
		ST_DIV,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	// request fields
	logic [3:0]         in_fi;
	logic [4:0]         in_ji;
	logic signed [12:0] in_ang;
	logic [9:0]         in_start;
	logic [9:0]         in_end;
	logic               accept;
	logic               fi_ok;
	logic               ji_ok;

	assign in_fi    = s_tdata[3:0];
	assign in_ji    = s_tdata[8:4];
	assign in_ang   = s_tdata[21:9];
	assign in_start = s_tdata[31:22];
	assign in_end   = s_tdata[41:32];
	assign accept   = s_tvalid && s_tready;
	assign fi_ok    = {4'd0, in_fi} < 8'(MAX_FRAMES);
	assign ji_ok    = {3'd0, in_ji} < 8'(MAX_JOINTS);

	state_t             state_q;
	logic [3:0]         fcount_q;
	logic [7:0]         deadband_q;
	logic [9:0]         elapsed_q;
	logic               finished_q;
	logic [7:0]         repeat_q;
	logic [4:0]         ji_q;
	logic signed [12:0] ang_q;
	logic               last_q;
	logic               jok_q;
	logic [FW-1:0]      f_q;
	logic [9:0]         last_end_q;
	logic [9:0]         rem_q;
	logic               have_q;
	logic               hold_q;
	logic               neg_q;
	logic signed [15:0] speed_q;
	kjmp_pkg::res_t     res_q;

	// keyframe tables
	logic [19:0]   fmem [MAX_FRAMES];
	logic [19:0]   frd_q;
	logic [FW-1:0] frd_addr;
	logic [12:0]   tmem [MAX_FRAMES * MAX_JOINTS];
	logic [12:0]   trd_q;
	logic [AW-1:0] trd_addr;
	logic [AW-1:0] twr_addr;

	logic [FW-1:0] lf;
	logic [9:0]    fr_start;
	logic [9:0]    fr_end;
	logic          match;

	// last frame in use, clamped to the table
	always_comb begin
		if (fcount_q == 4'd0) begin
			lf = FW'(1);
		end else if ({4'd0, fcount_q} > 8'(MAX_FRAMES - 1)) begin
			lf = FW'(MAX_FRAMES - 1);
		end else begin
			lf = FW'(fcount_q);
		end
	end

	always_comb begin
		case (state_q)
			ST_LAST: frd_addr = FW'(1);
			ST_SCAN: frd_addr = f_q + 1'b1;
			default: frd_addr = lf;
		endcase
	end

	assign trd_addr = AW'(f_q) * AW'(MAX_JOINTS) + AW'(ji_q);
	assign twr_addr = AW'(FW'(in_fi)) * AW'(MAX_JOINTS) + AW'(in_ji);

	always_ff @(posedge clk) begin
		if (accept && s_tuser == kjmp_pkg::KIND_FRAME && fi_ok) begin
			fmem[FW'(in_fi)] <= {in_end, in_start};
		end
		frd_q <= fmem[frd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept && s_tuser == kjmp_pkg::KIND_TARGET && fi_ok && ji_ok) begin
			tmem[twr_addr] <= in_ang;
		end
		trd_q <= tmem[trd_addr];
	end

	assign fr_start = frd_q[9:0];
	assign fr_end   = frd_q[19:10];
	assign match    = (fr_start < elapsed_q) && (elapsed_q <= fr_end);

	// error and divider operands
	logic signed [13:0] diff;
	logic [13:0]        mag;
	logic               in_band;
	logic [10:0]        next_tick;
	kjmp_pkg::div_req_t div_req;
	kjmp_pkg::div_sts_t div_sts;
	logic [15:0]        q_neg;

	always_comb begin
		diff    = {trd_q[12], trd_q} - {ang_q[12], ang_q};
		mag     = diff[13] ? 14'(-diff) : diff;
		in_band = (mag <= {6'd0, deadband_q});
		next_tick = {1'b0, elapsed_q} + 11'd1;
		q_neg   = 16'd0 - div_sts.quotient;
		div_req.start    = (state_q == ST_TCALC) && !in_band && (rem_q != 10'd0);
		div_req.dividend = {mag, 2'b00} + 16'(mag);
		div_req.divisor  = {rem_q, 2'b00};
	end

	kjmp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts)
	);

	logic push;
	logic ob_ready;

	assign push     = (state_q == ST_EMIT) && ob_ready;
	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fcount_q   <= 4'd10;
			deadband_q <= 8'd6;
			elapsed_q  <= '0;
			finished_q <= 1'b0;
			repeat_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					kjmp_pkg::REG_FRAME_COUNT: fcount_q <= cfg_wdata[3:0];
					kjmp_pkg::REG_DEADBAND:    deadband_q <= cfg_wdata;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (s_tuser)
							kjmp_pkg::KIND_RESTART: begin
								elapsed_q  <= '0;
								finished_q <= 1'b0;
							end
							kjmp_pkg::KIND_SAMPLE: begin
								ji_q    <= in_ji;
								ang_q   <= in_ang;
								last_q  <= s_tlast;
								jok_q   <= ji_ok;
								have_q  <= 1'b0;
								hold_q  <= 1'b0;
								speed_q <= '0;
								if (finished_q) begin
									elapsed_q <= '0;
									res_q <= '{joint: in_ji, speed: '0, holding: 1'b1,
										finished: 1'b0, repeat_total: repeat_q};
									if (ji_ok) begin
										state_q <= ST_EMIT;
									end
								end else begin
									state_q <= ST_LAST;
								end
							end
							default: ;
						endcase
					end
				end
				ST_LAST: begin
					last_end_q <= fr_end;
					f_q        <= FW'(1);
					state_q    <= jok_q ? ST_SCAN : ST_DECIDE;
				end
				ST_SCAN: begin
					if (match) begin
						rem_q   <= fr_end - elapsed_q;
						have_q  <= 1'b1;
						state_q <= ST_TCALC;
					end else if (f_q == lf) begin
						state_q <= ST_DECIDE;
					end else begin
						f_q <= f_q + 1'b1;
					end
				end
				ST_TCALC: begin
					neg_q <= diff[13];
					if (in_band) begin
						hold_q  <= 1'b1;
						state_q <= ST_DECIDE;
					end else if (rem_q == 10'd0) begin
						// no time left: full-scale command
						speed_q <= diff[13] ? -16'sd32767 : 16'sd32767;
						state_q <= ST_DECIDE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_sts.done) begin
						speed_q <= neg_q ? q_neg : div_sts.quotient;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (last_q && (next_tick > {1'b0, last_end_q})) begin
						finished_q <= 1'b1;
						repeat_q   <= repeat_q + 1'b1;
						elapsed_q  <= '0;
						res_q <= '{joint: ji_q, speed: '0, holding: 1'b1,
							finished: 1'b1, repeat_total: repeat_q + 1'b1};
						state_q <= ST_EMIT;
					end else begin
						if (last_q) begin
							elapsed_q <= next_tick[9:0];
						end
						res_q <= '{joint: ji_q, speed: speed_q, holding: hold_q,
							finished: 1'b0, repeat_total: repeat_q};
						state_q <= have_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (ob_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	kjmp_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.res      (res_q),
		.ready    (ob_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	`KJMP_ASSERT(a_fin_time_zero, clk, arst_n, finished_q, elapsed_q == 10'd0, "time runs while finished")
	`KJMP_ASSERT(a_div_idle_start, clk, arst_n, div_req.start, !div_sts.busy, "divider restarted while busy")
	`KJMP_ASSERT(a_div_wait, clk, arst_n, state_q == ST_DIV, div_sts.busy || div_sts.done, "waiting on idle divider")
	`KJMP_ASSERT(a_repeat_on_finish, clk, arst_n, repeat_q != $past(repeat_q), $rose(finished_q), "repeat count moved without finish")

endmodule
